[rtl/gic_pkg.sv]
// Package for the gamepad input conditioner: beat widths, field offsets,
// register indexes, reset values and the sequencer state type.
// No dependencies; used by the top level and by its checker.
`default_nettype none

package gic_pkg;

    // Field widths
    localparam int BTN_RAW_W = 12;
    localparam int BTN_W     = 14;
    localparam int AXIS_W    = 8;
    localparam int CFG_W     = 7;
    localparam int DIR_W     = 4;
    localparam int CFG_ADDR_W = 2;

    // Input beat: raw_buttons, raw_x, raw_y, query_mask (low to high)
    localparam int S_RAWB_LSB  = 0;
    localparam int S_RAWX_LSB  = S_RAWB_LSB + BTN_RAW_W;
    localparam int S_RAWY_LSB  = S_RAWX_LSB + AXIS_W;
    localparam int S_MASK_LSB  = S_RAWY_LSB + AXIS_W;
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = 1;

    // Output beat: pressed, went_down, went_up, held, stick_x, stick_y,
    // direction, direction_new (low to high)
    localparam int M_PRESS_LSB = 0;
    localparam int M_DOWN_LSB  = M_PRESS_LSB + BTN_W;
    localparam int M_UP_LSB    = M_DOWN_LSB + BTN_W;
    localparam int M_HELD_LSB  = M_UP_LSB + BTN_W;
    localparam int M_SX_LSB    = M_HELD_LSB + BTN_W;
    localparam int M_SY_LSB    = M_SX_LSB + AXIS_W;
    localparam int M_DIR_LSB   = M_SY_LSB + AXIS_W;
    localparam int M_DNEW_LSB  = M_DIR_LSB + DIR_W;
    localparam int M_TDATA_W   = M_DNEW_LSB + DIR_W;

    // Register indexes on the configuration channel
    localparam logic [CFG_ADDR_W-1:0] REG_DEAD_ZONE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] DEAD_ZONE_RST = 7'd36;
    localparam logic [CFG_W-1:0] RANGE_RST     = 7'd80;
    localparam logic [CFG_W-1:0] THRESHOLD_RST = 7'd40;

    // Axis center and quotient bits of the axis divider
    localparam logic [AXIS_W-1:0] AXIS_CENTER = 8'd128;
    localparam int QUO_W = 7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } gic_state_t;

endpackage : gic_pkg

`default_nettype wire

[rtl/gamepad_input_conditioner_top.sv]
// Gamepad input conditioner top level: button remap, edge detection, stick
// deadzone and rescale through a bit-serial divider per axis.
// Depends on gic_pkg.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-------------------------------------
//  s_      | in  | s_tvalid / s_tready    | s_tdata, s_tuser (sample_ok)
//  m_      | out | m_tvalid / m_tready    | m_tdata
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_addr, cfg_wdata
//
// From acceptance to the result register a beat passes ST_MUL to multiply,
// seven ST_DIV restoring-divide steps (one quotient bit per step in each axis
// divider) and ST_FIN to update state; s_tready rises again the next cycle, so
// one beat is through before the next. A new beat is taken once the result is
// loaded, even while it waits on m_tready; a result still waiting holds ST_FIN.
// Reset (aresetn low, synchronous) restores the registers and clears state.
`default_nettype none

module gamepad_input_conditioner_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // raw_buttons[11:0], raw_x[19:12], raw_y[27:20], query_mask[41:28], zero pad
    input  wire logic [gic_pkg::S_TDATA_W-1:0] s_tdata,
    // sample_ok[0]
    input  wire logic [gic_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // pressed[13:0], went_down[27:14], went_up[41:28], held[55:42],
    // stick_x[63:56], stick_y[71:64], direction[75:72], direction_new[79:76]
    output logic [gic_pkg::M_TDATA_W-1:0]      m_tdata,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gic_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [gic_pkg::CFG_W-1:0]     cfg_wdata
);
    import gic_pkg::*;

    gic_state_t state_reg, state_next;

    logic [CFG_W-1:0] dead_zone_reg, range_reg, threshold_reg;

    // Captured sample
    logic                 ok_reg;
    logic [BTN_RAW_W-1:0] raw_btn_reg;
    logic [AXIS_W-1:0]    raw_axis_reg [2];
    logic [BTN_W-1:0]     mask_reg;

    // Block state; the current values also serve as the previous ones
    // when the next beat is conditioned
    logic [BTN_W-1:0]        cur_btn_reg;
    logic signed [AXIS_W-1:0] cur_sx_reg, cur_sy_reg;

    // Axis divider datapath, index 0 is X, 1 is Y
    logic [QUO_W-1:0]  num_lo_reg [2];
    logic [QUO_W-1:0]  num_lo_next [2];
    logic [AXIS_W-1:0] rem_reg [2];
    logic [AXIS_W-1:0] rem_next [2];
    logic [QUO_W-1:0]  quo_reg [2];
    logic [QUO_W-1:0]  quo_next [2];
    logic              zero_reg [2];
    logic              zero_next [2];
    logic              neg_reg [2];
    logic              neg_next [2];
    logic [2:0]        cnt_reg, cnt_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic accept, load_out;

    logic [AXIS_W-1:0] den;
    logic [AXIS_W-1:0] mag [2];
    logic [AXIS_W-1:0] excess [2];
    logic [14:0]       prod [2];
    logic [AXIS_W:0]   trial [2];
    logic [AXIS_W:0]   diff [2];

    logic [BTN_W-1:0]         new_btn;
    logic signed [AXIS_W-1:0] new_sx, new_sy;
    logic [BTN_W-1:0]         nxt_btn;
    logic signed [AXIS_W-1:0] nxt_sx, nxt_sy;
    logic [DIR_W-1:0]         old_dir, nxt_dir;
    logic [M_TDATA_W-1:0]     out_beat;

    // Direction bits from a stick pair and a button vector
    function automatic logic [DIR_W-1:0] dir_of(
        input logic [BTN_W-1:0]         btn,
        input logic signed [AXIS_W-1:0] sx,
        input logic signed [AXIS_W-1:0] sy,
        input logic [CFG_W-1:0]         thr
    );
        logic signed [AXIS_W-1:0] pos_t;
        logic signed [AXIS_W-1:0] neg_t;
        logic [DIR_W-1:0]         r;
        pos_t = $signed({1'b0, thr});
        neg_t = -pos_t;
        r[0] = (sy > pos_t) || btn[4];
        r[1] = (sy < neg_t) || btn[5];
        r[2] = (sx > pos_t) || btn[7];
        r[3] = (sx < neg_t) || btn[6];
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // Configuration writes; unknown indexes fall through
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg <= DEAD_ZONE_RST;
            range_reg     <= RANGE_RST;
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_addr)
                REG_DEAD_ZONE: dead_zone_reg <= cfg_wdata;
                REG_RANGE:     range_reg     <= cfg_wdata;
                REG_THRESHOLD: threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake controls
    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        accept   = s_tvalid && s_tready;
        load_out = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 3'(QUO_W - 1)) state_next = ST_FIN;
            ST_FIN:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Capture the sample beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg          <= s_tuser[0];
            raw_btn_reg     <= s_tdata[S_RAWB_LSB +: BTN_RAW_W];
            raw_axis_reg[0] <= s_tdata[S_RAWX_LSB +: AXIS_W];
            raw_axis_reg[1] <= s_tdata[S_RAWY_LSB +: AXIS_W];
            mask_reg        <= s_tdata[S_MASK_LSB +: BTN_W];
        end
    end

    // Divisor: 128 - dead_zone, never zero
    assign den = AXIS_CENTER - {1'b0, dead_zone_reg};

    // Axis datapath: magnitude and product, then one quotient bit per cycle.
    // Since (m - dz) <= den, the quotient never exceeds the range, so it fits
    // in seven bits and the top seven dividend bits start below den.
    always_comb begin
        for (int a = 0; a < 2; a++) begin
            mag[a]    = raw_axis_reg[a][7] ? {1'b0, raw_axis_reg[a][6:0]}
                                           : AXIS_CENTER - raw_axis_reg[a];
            excess[a] = mag[a] - {1'b0, dead_zone_reg};
            prod[a]   = 15'(excess[a]) * 15'(range_reg);
            trial[a]  = {rem_reg[a], num_lo_reg[a][QUO_W-1]};
            diff[a]   = trial[a] - {1'b0, den};

            num_lo_next[a] = num_lo_reg[a];
            rem_next[a]    = rem_reg[a];
            quo_next[a]    = quo_reg[a];
            zero_next[a]   = zero_reg[a];
            neg_next[a]    = neg_reg[a];

            unique case (state_reg)
                ST_MUL: begin
                    zero_next[a]   = (mag[a] <= {1'b0, dead_zone_reg});
                    neg_next[a]    = !raw_axis_reg[a][7];
                    rem_next[a]    = {1'b0, prod[a][13:7]};
                    num_lo_next[a] = prod[a][6:0];
                    quo_next[a]    = '0;
                end
                ST_DIV: begin
                    num_lo_next[a] = {num_lo_reg[a][QUO_W-2:0], 1'b0};
                    if (trial[a] >= {1'b0, den}) begin
                        rem_next[a] = diff[a][AXIS_W-1:0];
                        quo_next[a] = {quo_reg[a][QUO_W-2:0], 1'b1};
                    end else begin
                        rem_next[a] = trial[a][AXIS_W-1:0];
                        quo_next[a] = {quo_reg[a][QUO_W-2:0], 1'b0};
                    end
                end
                default: ;
            endcase
        end
        cnt_next = (state_reg == ST_DIV) ? cnt_reg + 3'd1 : 3'd0;
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 2; a++) begin
            num_lo_reg[a] <= num_lo_next[a];
            rem_reg[a]    <= rem_next[a];
            quo_reg[a]    <= quo_next[a];
            zero_reg[a]   <= zero_next[a];
            neg_reg[a]    <= neg_next[a];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    // Conditioned sample and the state after this beat
    always_comb begin
        new_btn = {raw_btn_reg[1], raw_btn_reg[2], raw_btn_reg};
        if (zero_reg[0]) begin
            new_sx = '0;
        end else if (neg_reg[0]) begin
            new_sx = -$signed({1'b0, quo_reg[0]});
        end else begin
            new_sx = $signed({1'b0, quo_reg[0]});
        end
        // Y grows downward on the pad, so flip its sign
        if (zero_reg[1]) begin
            new_sy = '0;
        end else if (neg_reg[1]) begin
            new_sy = $signed({1'b0, quo_reg[1]});
        end else begin
            new_sy = -$signed({1'b0, quo_reg[1]});
        end

        nxt_btn = ok_reg ? new_btn : cur_btn_reg;
        nxt_sx  = ok_reg ? new_sx  : cur_sx_reg;
        nxt_sy  = ok_reg ? new_sy  : cur_sy_reg;
        old_dir = dir_of(cur_btn_reg, cur_sx_reg, cur_sy_reg, threshold_reg);
        nxt_dir = dir_of(nxt_btn, nxt_sx, nxt_sy, threshold_reg);

        out_beat = {
            nxt_dir & ~old_dir,
            nxt_dir,
            nxt_sy,
            nxt_sx,
            nxt_btn & cur_btn_reg & mask_reg,
            ~nxt_btn & cur_btn_reg & mask_reg,
            nxt_btn & ~cur_btn_reg & mask_reg,
            nxt_btn & mask_reg
        };
    end

    // Update state when the result is loaded
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_btn_reg  <= '0;
            cur_sx_reg   <= '0;
            cur_sy_reg   <= '0;
        end else if (load_out) begin
            cur_btn_reg  <= nxt_btn;
            cur_sx_reg   <= nxt_sx;
            cur_sy_reg   <= nxt_sy;
        end
    end

    // Output register
    always_comb begin
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= out_beat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule : gamepad_input_conditioner_top

`default_nettype wire

[rtl/gic_checker.sv]
// Port-level checker for the gamepad input conditioner, bound to the top.
// Depends on gic_pkg for beat field offsets.
`default_nettype none

module gic_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [gic_pkg::M_TDATA_W-1:0]   m_tdata
);
    import gic_pkg::*;

    logic [BTN_W-1:0]  pressed, went_down, went_up, held;
    logic [AXIS_W-1:0] sx, sy;
    logic [DIR_W-1:0]  dir, dir_new;

    assign pressed   = m_tdata[M_PRESS_LSB +: BTN_W];
    assign went_down = m_tdata[M_DOWN_LSB +: BTN_W];
    assign went_up   = m_tdata[M_UP_LSB +: BTN_W];
    assign held      = m_tdata[M_HELD_LSB +: BTN_W];
    assign sx        = m_tdata[M_SX_LSB +: AXIS_W];
    assign sy        = m_tdata[M_SY_LSB +: AXIS_W];
    assign dir       = m_tdata[M_DIR_LSB +: DIR_W];
    assign dir_new   = m_tdata[M_DNEW_LSB +: DIR_W];

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed under stall");

    // One beat in work at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

    // Pressed splits into newly down and held, with no overlap; released ones are not pressed
    a_btn_split: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((held | went_down) == pressed) && ((held & went_down) == '0)
                     && ((went_up & pressed) == '0))
        else $error("button vectors inconsistent");

    // New directions are a subset of the directions
    a_dir_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (dir_new & ~dir) == '0)
        else $error("direction_new outside direction");

    // Conditioned axes stay within +/-127
    a_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (sx != 8'h80) && (sy != 8'h80))
        else $error("stick value out of range");

endmodule : gic_checker

bind gamepad_input_conditioner_top gic_checker u_gic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

[test/tb_gamepad_input_conditioner_top.sv]
// Self-checking testbench for gamepad_input_conditioner_top: a directed sample table, then
// register sweeps with random pad traffic, results checked against a predictor or pinned reports.
// Depends on gic_pkg and the gamepad_input_conditioner_top RTL.
module tb_gamepad_input_conditioner_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gic_pkg::*;

    // Register index that decodes to nothing
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    // Raw button bits that also set the face buttons
    localparam int RAW_CIRCLE = 1;
    localparam int RAW_CROSS  = 2;

    // Conditioned button bits used for directions
    localparam int PAD_UP    = 4;
    localparam int PAD_DOWN  = 5;
    localparam int PAD_LEFT  = 6;
    localparam int PAD_RIGHT = 7;

    // Direction bits
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_RIGHT = 2;
    localparam int DIR_LEFT  = 3;

    localparam logic [BTN_W-1:0] ALL_BUTTONS = 14'h3FFF;

    localparam int ITEMS_PER_PHASE = 50;
    localparam int PHASES          = 15;
    localparam int SETTLE_CYCLES   = 16;
    localparam int STALL_LIMIT     = 2000;

    // One result beat, pressed in the lowest bits as on m_tdata
    typedef struct packed {
        logic [DIR_W-1:0]  dir_new;
        logic [DIR_W-1:0]  dir;
        logic [AXIS_W-1:0] stick_y;
        logic [AXIS_W-1:0] stick_x;
        logic [BTN_W-1:0]  held;
        logic [BTN_W-1:0]  went_up;
        logic [BTN_W-1:0]  went_down;
        logic [BTN_W-1:0]  pressed;
    } pad_report_t;

    // One pad sample, optionally with a hand-written expected report
    typedef struct packed {
        logic              pinned;
        pad_report_t       report;
        logic [BTN_W-1:0]  mask;
        logic [AXIS_W-1:0] y;
        logic [AXIS_W-1:0] x;
        logic [BTN_RAW_W-1:0] buttons;
        logic              ok;
    } pad_sample_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;

    // Hand-written expectation traveling with the current input beat
    logic        pin_flag;
    pad_report_t pin_report;

    // Predictor copy of the registers and the pad state
    logic [CFG_W-1:0] dz_reg;
    logic [CFG_W-1:0] range_reg;
    logic [CFG_W-1:0] thr_reg;
    logic [BTN_W-1:0] cur_btn;
    logic [BTN_W-1:0] prev_btn;
    int               cur_sx;
    int               cur_sy;
    logic [DIR_W-1:0] prev_dir;

    pad_report_t pending_reports[$];
    pad_sample_t directed_rows[$];

    logic tx_idle;
    logic rx_idle;
    int   err_count;
    int   n_samples;
    int   n_invalid;
    int   n_reports;
    int   n_reg_writes;
    int   stall_cycles;

    gamepad_input_conditioner_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Deadzone, rescale and clamp of one raw axis; sign follows the deflection
    function automatic int shape_axis(logic [AXIS_W-1:0] raw);
        int dev;
        int mag;
        int dz;
        int rg;
        int s;
        dev = int'(raw) - int'(AXIS_CENTER);
        mag = (dev < 0) ? -dev : dev;
        dz  = int'(dz_reg);
        rg  = int'(range_reg);
        if (mag <= dz)
            return 0;
        s = ((mag - dz) * rg) / (int'(AXIS_CENTER) - dz);
        if (s > rg)
            s = rg;
        return (dev < 0) ? -s : s;
    endfunction

    // Direction from stick beyond threshold or d-pad button
    function automatic logic [DIR_W-1:0] pad_direction(logic [BTN_W-1:0] btn, int sx, int sy);
        logic [DIR_W-1:0] d;
        int t;
        t = int'(thr_reg);
        d = '0;
        d[DIR_UP]    = (sy > t)  || btn[PAD_UP];
        d[DIR_DOWN]  = (sy < -t) || btn[PAD_DOWN];
        d[DIR_RIGHT] = (sx > t)  || btn[PAD_RIGHT];
        d[DIR_LEFT]  = (sx < -t) || btn[PAD_LEFT];
        return d;
    endfunction

    // Age the state, take a valid sample, and build the report
    function automatic pad_report_t condition_sample(pad_sample_t smp);
        pad_report_t r;
        logic [DIR_W-1:0] dir_now;
        prev_btn = cur_btn;
        prev_dir = pad_direction(cur_btn, cur_sx, cur_sy);
        if (smp.ok) begin
            cur_btn = {smp.buttons[RAW_CIRCLE], smp.buttons[RAW_CROSS], smp.buttons};
            cur_sx  = shape_axis(smp.x);
            cur_sy  = -shape_axis(smp.y);
        end
        dir_now     = pad_direction(cur_btn, cur_sx, cur_sy);
        r.pressed   = cur_btn & smp.mask;
        r.went_down = cur_btn & ~prev_btn & smp.mask;
        r.went_up   = ~cur_btn & prev_btn & smp.mask;
        r.held      = cur_btn & prev_btn & smp.mask;
        r.stick_x   = AXIS_W'(cur_sx);
        r.stick_y   = AXIS_W'(cur_sy);
        r.dir       = dir_now;
        r.dir_new   = dir_now & ~prev_dir;
        return r;
    endfunction

    // Raw axis value aimed at the deadzone, its edge, the ends, or anywhere
    function automatic logic [AXIS_W-1:0] pick_axis();
        int off;
        case ($urandom_range(0, 4))
            0: off = $urandom_range(0, dz_reg);
            1: off = int'(dz_reg) + $urandom_range(0, 2);
            2: begin
                case ($urandom_range(0, 3))
                    0: return 8'd0;
                    1: return 8'd1;
                    2: return 8'd254;
                    default: return 8'd255;
                endcase
            end
            default: return AXIS_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 1))
            return (off > 127) ? 8'd255 : AXIS_W'(128 + off);
        return (off > 128) ? 8'd0 : AXIS_W'(128 - off);
    endfunction

    function automatic void add_row(logic ok, logic [BTN_RAW_W-1:0] b, logic [AXIS_W-1:0] x,
                                    logic [AXIS_W-1:0] y, logic [BTN_W-1:0] mask);
        pad_sample_t row;
        row = '0;
        row.ok = ok;
        row.buttons = b;
        row.x = x;
        row.y = y;
        row.mask = mask;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_pinned(logic ok, logic [BTN_RAW_W-1:0] b, logic [AXIS_W-1:0] x,
                                       logic [AXIS_W-1:0] y, logic [BTN_W-1:0] mask,
                                       pad_report_t rep);
        pad_sample_t row;
        row.ok = ok;
        row.buttons = b;
        row.x = x;
        row.y = y;
        row.mask = mask;
        row.pinned = 1'b1;
        row.report = rep;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // Present one sample, after a random gap while tx_idle is set, and hold it until the beat is taken
    task automatic send_sample(pad_sample_t smp);
        int gap;
        logic [S_TDATA_W-1:0] word;
        gap = tx_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[S_RAWB_LSB +: BTN_RAW_W] = smp.buttons;
        word[S_RAWX_LSB +: AXIS_W]    = smp.x;
        word[S_RAWY_LSB +: AXIS_W]    = smp.y;
        word[S_MASK_LSB +: BTN_W]     = smp.mask;
        s_tdata    <= word;
        s_tuser    <= smp.ok;
        pin_flag   <= smp.pinned;
        pin_report <= smp.report;
        s_tvalid   <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending, wait out every outstanding result, then let the bench settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_addr  <= idx;
        cfg_wdata <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Extremes first, then random register settings
    task automatic phase_setting(input int phase, output logic [CFG_W-1:0] dz,
                                 output logic [CFG_W-1:0] rg, output logic [CFG_W-1:0] thr);
        case (phase)
            0: begin dz = 7'd0;   rg = 7'd127; thr = 7'd0;   end
            1: begin dz = 7'd127; rg = 7'd127; thr = 7'd127; end
            2: begin dz = 7'd36;  rg = 7'd0;   thr = 7'd40;  end
            3: begin dz = 7'd127; rg = 7'd1;   thr = 7'd0;   end
            4: begin dz = 7'd0;   rg = 7'd1;   thr = 7'd127; end
            5: begin dz = 7'd64;  rg = 7'd127; thr = 7'd63;  end
            default: begin
                dz  = CFG_W'($urandom_range(0, 127));
                rg  = ($urandom_range(0, 7) == 0) ? 7'd0 : CFG_W'($urandom_range(1, 127));
                thr = CFG_W'($urandom_range(0, 127));
            end
        endcase
    endtask

    // Predict on every accepted sample; a pinned row supplies its own expectation
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin : take_sample
            pad_sample_t smp;
            pad_report_t predicted;
            smp         = '0;
            smp.ok      = s_tuser[0];
            smp.buttons = s_tdata[S_RAWB_LSB +: BTN_RAW_W];
            smp.x       = s_tdata[S_RAWX_LSB +: AXIS_W];
            smp.y       = s_tdata[S_RAWY_LSB +: AXIS_W];
            smp.mask    = s_tdata[S_MASK_LSB +: BTN_W];
            predicted   = condition_sample(smp);
            pending_reports.push_back(pin_flag ? pin_report : predicted);
            n_samples++;
            if (!smp.ok)
                n_invalid++;
        end
    end

    // Mirror register writes into the predictor
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            n_reg_writes++;
            case (cfg_addr)
                REG_DEAD_ZONE: dz_reg    = cfg_wdata;
                REG_RANGE:     range_reg = cfg_wdata;
                REG_THRESHOLD: thr_reg   = cfg_wdata;
                default: ;
            endcase
        end
    end

    // Compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin : check_report
            pad_report_t got;
            pad_report_t want;
            got = pad_report_t'(m_tdata);
            n_reports++;
            if (pending_reports.size() == 0) begin
                $error("result beat with no sample outstanding: 0x%0h", m_tdata);
                err_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("pressed", want.pressed, got.pressed);
                check_field("went_down", want.went_down, got.went_down);
                check_field("went_up", want.went_up, got.went_up);
                check_field("held", want.held, got.held);
                check_field("stick_x", want.stick_x, got.stick_x);
                check_field("stick_y", want.stick_y, got.stick_y);
                check_field("direction", want.dir, got.dir);
                check_field("direction_new", want.dir_new, got.dir_new);
            end
        end
    end

    // Abort when no beat moves on any channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $error("no beat moved for %0d cycles", STALL_LIMIT);
                $display("** gamepad_input_conditioner_top: FAILED **");
                $finish;
            end
        end
    end

    // Result sink: random stall before each beat, none while rx_idle is low
    initial begin : result_sink
        int hold;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            hold = rx_idle ? $urandom_range(0, 19) : 0;
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        pad_sample_t row;
        logic [CFG_W-1:0] set_dz;
        logic [CFG_W-1:0] set_rg;
        logic [CFG_W-1:0] set_thr;
        logic [BTN_RAW_W-1:0] walk_btn;
        int phase;
        int n;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        cfg_valid  = 1'b0;
        cfg_addr   = '0;
        cfg_wdata  = '0;
        pin_flag   = 1'b0;
        pin_report = '0;
        tx_idle    = 1'b1;
        rx_idle    = 1'b1;
        err_count  = 0;
        n_samples  = 0;
        n_invalid  = 0;
        n_reports  = 0;
        n_reg_writes = 0;
        stall_cycles = 0;
        dz_reg    = DEAD_ZONE_RST;
        range_reg = RANGE_RST;
        thr_reg   = THRESHOLD_RST;
        cur_btn   = '0;
        prev_btn  = '0;
        cur_sx    = 0;
        cur_sy    = 0;
        prev_dir  = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table under the reset register values
        add_pinned(1'b1, 12'h000, 8'd128, 8'd128, ALL_BUTTONS, '0);
        add_pinned(1'b1, 12'hFFF, 8'd0, 8'd0, ALL_BUTTONS,
                   {4'hF, 4'hF, 8'h50, 8'hB0, 14'h0, 14'h0, 14'h3FFF, 14'h3FFF});
        add_pinned(1'b1, 12'hFFF, 8'd0, 8'd0, ALL_BUTTONS,
                   {4'h0, 4'hF, 8'h50, 8'hB0, 14'h3FFF, 14'h0, 14'h0, 14'h3FFF});
        add_pinned(1'b1, 12'h000, 8'd128, 8'd128, ALL_BUTTONS,
                   {4'h0, 4'h0, 8'h00, 8'h00, 14'h0, 14'h3FFF, 14'h0, 14'h0});
        add_pinned(1'b1, 12'hFFF, 8'd255, 8'd255, 14'h0,
                   {4'hF, 4'hF, 8'hB1, 8'h4F, 14'h0, 14'h0, 14'h0, 14'h0});
        // invalid sample: raw fields ignored, previous state aged
        add_pinned(1'b0, BTN_RAW_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                   ALL_BUTTONS, {4'h0, 4'hF, 8'hB1, 8'h4F, 14'h3FFF, 14'h0, 14'h0, 14'h3FFF});
        add_row(1'b0, BTN_RAW_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom), ALL_BUTTONS);
        // circle and cross also set B and A; axes on both sides of the deadzone edge
        add_row(1'b1, 12'h002, 8'd164, 8'd92, ALL_BUTTONS);
        add_row(1'b1, 12'h004, 8'd165, 8'd91, ALL_BUTTONS);
        add_row(1'b1, 12'h010, 8'd200, 8'd128, ALL_BUTTONS);
        add_row(1'b1, 12'h020, 8'd128, 8'd30, ALL_BUTTONS);
        add_row(1'b1, 12'h040, 8'd50, 8'd128, ALL_BUTTONS);
        add_row(1'b1, 12'h080, 8'd128, 8'd220, ALL_BUTTONS);
        add_row(1'b1, 12'h100, 8'd1, 8'd254, ALL_BUTTONS);
        add_row(1'b1, 12'h200, 8'd127, 8'd129, ALL_BUTTONS);
        add_row(1'b1, 12'h400, 8'd211, 8'd45, ALL_BUTTONS);
        add_row(1'b1, 12'h800, 8'd212, 8'd44, ALL_BUTTONS);
        add_row(1'b1, 12'h009, 8'd44, 8'd212, 14'h1555);
        add_row(1'b1, 12'hFFF, 8'd45, 8'd211, 14'h2AAA);
        add_row(1'b1, 12'h555, 8'd255, 8'd0, ALL_BUTTONS);
        add_row(1'b1, 12'hAAA, 8'd0, 8'd255, ALL_BUTTONS);
        add_row(1'b1, 12'h000, 8'd128, 8'd128, 14'h0);

        foreach (directed_rows[i])
            send_sample(directed_rows[i]);
        drain();

        // Register sweeps with random pad traffic
        walk_btn = '0;
        for (phase = 0; phase < PHASES; phase++) begin
            phase_setting(phase, set_dz, set_rg, set_thr);
            if (phase == 0 || $urandom_range(0, 1))
                write_reg(REG_UNUSED, CFG_W'($urandom));
            write_reg(REG_DEAD_ZONE, set_dz);
            write_reg(REG_RANGE, set_rg);
            write_reg(REG_THRESHOLD, set_thr);
            cfg_valid <= 1'b0;
            tx_idle = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                row = '0;
                case ($urandom_range(0, 9))
                    0: begin
                        row.ok = 1'b0;
                        walk_btn = walk_btn;
                    end
                    1: begin
                        row.ok = 1'b1;
                        walk_btn = BTN_RAW_W'($urandom);
                    end
                    default: begin
                        // press, hold and release a few buttons at a time
                        row.ok = 1'b1;
                        repeat ($urandom_range(0, 2))
                            walk_btn[$urandom_range(0, BTN_RAW_W - 1)] ^= 1'b1;
                    end
                endcase
                row.buttons = row.ok ? walk_btn : BTN_RAW_W'($urandom);
                row.x = pick_axis();
                row.y = pick_axis();
                row.mask = ($urandom_range(0, 9) < 7) ? ALL_BUTTONS : BTN_W'($urandom);
                send_sample(row);
            end
            drain();
        end

        $display("Sent %0d pad samples (%0d invalid) across %0d register settings, %0d writes.",
                 n_samples, n_invalid, PHASES + 1, n_reg_writes);
        $display("Compared %0d result beats field by field, %0d mismatches.",
                 n_reports, err_count);
        if (err_count == 0) begin
            $display("** gamepad_input_conditioner_top: PASSED **");
        end else begin
            $display("** gamepad_input_conditioner_top: FAILED **");
        end
        $finish;
    end

endmodule
